### hdl/assert_macros.svh
// assertion macros used by tiered_poll_scheduler_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### hdl/tps_pkg.sv
// package for the tiered poll scheduler: codes, constants and types
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;
	localparam int unsigned MaxEntriesDefault = 32;
	localparam logic [31:0] ReinitMs = 32'd30000;
	localparam logic [31:0] BackoffShortMs = 32'd5000;
	localparam logic [31:0] BackoffLongMs = 32'd30000;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_ADD = 3'd1,
		OP_SUPPORT = 3'd2,
		OP_POLL = 3'd3,
		OP_REPLY = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_REQUEST = 3'd1,
		ACT_REINIT = 3'd2,
		ACT_FORWARD = 3'd3,
		ACT_STATUS = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		REG_BASE = 3'd0,
		REG_TIER1 = 3'd1,
		REG_TIER2 = 3'd2,
		REG_TIER3 = 3'd3,
		REG_STATUS = 3'd4
	} reg_idx_t;
endpackage
`default_nettype wire

### hdl/tiered_poll_scheduler_core.sv
// tiered poll scheduler: entry table, round-robin scan and reply handling
// add, clear and reply: accept, then ST_EXEC, then result valid in ST_DONE
// support map: ST_EXEC, then ST_MAP at one table entry per cycle, then ST_DONE
// poll tick: EXEC, WRAP, then SCAN and MUL per entry, then DONE; EXEC to DONE if idle
// one item at a time; in_stall stays high from accept until the result is taken
// reset: arst_n clears control state and registers go to their documented values
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tiered_poll_scheduler_core #(
	parameter int unsigned MAX_ENTRIES = tps_pkg::MaxEntriesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] op,
	input wire logic [31:0] now_ms,
	input wire logic link_ready,
	input wire logic [7:0] entry_id,
	input wire logic [1:0] entry_tier,
	input wire logic support_known,
	input wire logic [31:0] support_bits,
	input wire logic reply_ok,
	input wire logic reply_no_data,
	input wire logic reply_has_data,
	input wire logic [7:0] reply_first_byte,
	input wire logic [4:0] stored_code_count,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] action,
	output logic [7:0] request_id,
	output logic lamp_on,
	output logic [6:0] ecu_code_count,
	output logic fetch_codes,
	output logic entry_disabled
);
	import tps_pkg::*;

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EXEC = 7'b0000010,
		ST_MAP = 7'b0000100,
		ST_SCAN = 7'b0001000,
		ST_MUL = 7'b0010000,
		ST_DONE = 7'b0100000,
		ST_WRAP = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] base_q;
	logic [7:0] mult1_q, mult2_q, mult3_q, status_id_q;

	// entry tables, one register per entry, read at the pointer or the pending index
	logic [7:0] id_q [MAX_ENTRIES];
	logic [1:0] tier_q [MAX_ENTRIES];
	logic [31:0] last_poll_q [MAX_ENTRIES];
	logic sup_q [MAX_ENTRIES];
	logic [1:0] nd_q [MAX_ENTRIES];

	logic [CW-1:0] count_q;
	logic [IW-1:0] scan_q, pend_idx_q, ptr_q;
	logic [CW-1:0] left_q;
	logic [3:0] fail_q;
	logic [31:0] last_att_q, last_init_q, pend_time_q;
	logic pend_valid_q;
	logic lamp_q;
	logic [6:0] codes_q;

	// latched item
	logic [2:0] op_q;
	logic [31:0] now_q, bits_q;
	logic link_q, known_q, r_ok_q, r_nd_q, r_has_q;
	logic [7:0] e_id_q, r_byte_q;
	logic [1:0] e_tier_q;
	logic [4:0] stored_q;

	// shared multiplier result and elapsed time for the current entry
	logic [31:0] ivl_q, elapsed_q;
	logic [2:0] act_q;
	logic [7:0] req_q;
	logic fetch_q, dis_q;

	logic in_acc, out_acc;
	logic [IW-1:0] next_idx;
	logic [7:0] mult_sel;
	logic [31:0] wait_ms;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	// round-robin successor of the scan index, valid while the index is below the count
	assign next_idx = ({1'b0, scan_q} + 1'b1 >= (IW + 1)'(count_q)) ? '0 : scan_q + 1'b1;

	// multiplier for the tier of the entry under the pointer
	always_comb begin
		unique case (tier_q[ptr_q])
			2'd1: mult_sel = mult1_q;
			2'd2: mult_sel = mult2_q;
			2'd3: mult_sel = mult3_q;
			default: mult_sel = 8'd1;
		endcase
	end

	assign wait_ms = (fail_q >= 4'd10) ? BackoffLongMs : BackoffShortMs;

	assign action = act_q;
	assign request_id = req_q;
	assign lamp_on = lamp_q;
	assign ecu_code_count = codes_q;
	assign fetch_codes = fetch_q;
	assign entry_disabled = dis_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 16'd100;
			mult1_q <= 8'd1;
			mult2_q <= 8'd4;
			mult3_q <= 8'd20;
			status_id_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE: base_q <= cfg_data;
				REG_TIER1: mult1_q <= cfg_data[7:0];
				REG_TIER2: mult2_q <= cfg_data[7:0];
				REG_TIER3: mult3_q <= cfg_data[7:0];
				REG_STATUS: status_id_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= op;
			now_q <= now_ms;
			link_q <= link_ready;
			e_id_q <= entry_id;
			e_tier_q <= entry_tier;
			known_q <= support_known;
			bits_q <= support_bits;
			r_ok_q <= reply_ok;
			r_nd_q <= reply_no_data;
			r_has_q <= reply_has_data;
			r_byte_q <= reply_first_byte;
			stored_q <= stored_code_count;
		end
	end

	// table payload (no reset, reads of unwritten entries are don't-care)
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && op_q == OP_ADD && count_q < CW'(MAX_ENTRIES)) begin
			id_q[count_q[IW-1:0]] <= e_id_q;
			tier_q[count_q[IW-1:0]] <= e_tier_q;
			last_poll_q[count_q[IW-1:0]] <= '0;
		end
		if (state_q == ST_EXEC && op_q == OP_REPLY && pend_valid_q
				&& CW'(pend_idx_q) < count_q && r_ok_q) begin
			last_poll_q[pend_idx_q] <= pend_time_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q <= '0;
			ptr_q <= '0;
			left_q <= '0;
			fail_q <= '0;
			last_att_q <= '0;
			last_init_q <= '0;
			pend_idx_q <= '0;
			pend_time_q <= '0;
			pend_valid_q <= 1'b0;
			lamp_q <= 1'b0;
			codes_q <= '0;
			act_q <= ACT_NONE;
			req_q <= '0;
			fetch_q <= 1'b0;
			dis_q <= 1'b0;
			ivl_q <= '0;
			elapsed_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				nd_q[i] <= '0;
				sup_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					act_q <= ACT_NONE;
					req_q <= '0;
					fetch_q <= 1'b0;
					dis_q <= 1'b0;
					state_q <= ST_DONE;
					case (op_q)
						OP_CLEAR: begin
							count_q <= '0;
							pend_valid_q <= 1'b0;
						end
						OP_ADD: begin
							if (count_q < CW'(MAX_ENTRIES)) begin
								sup_q[count_q[IW-1:0]] <= 1'b1;
								count_q <= count_q + 1'b1;
							end
						end
						OP_SUPPORT: begin
							ptr_q <= '0;
							left_q <= count_q;
							state_q <= ST_MAP;
						end
						OP_POLL: begin
							if (!link_q) begin
								if (now_q - last_init_q >= ReinitMs) begin
									act_q <= ACT_REINIT;
									last_init_q <= now_q;
								end
							end else if (count_q != '0 && !(fail_q >= 4'd3
									&& now_q - last_att_q < wait_ms)) begin
								left_q <= CW'(scan_q) + CW'(1);
								state_q <= ST_WRAP;
							end
						end
						OP_REPLY: begin
							if (pend_valid_q && CW'(pend_idx_q) < count_q) begin
								pend_valid_q <= 1'b0;
								req_q <= id_q[pend_idx_q];
								if (r_ok_q) begin
									if (id_q[pend_idx_q] == status_id_q && r_has_q) begin
										lamp_q <= r_byte_q[7];
										codes_q <= r_byte_q[6:0];
										fetch_q <= (r_byte_q[6:0] != '0) && (stored_q == '0);
										act_q <= ACT_STATUS;
									end else begin
										act_q <= ACT_FORWARD;
									end
									nd_q[pend_idx_q] <= '0;
									fail_q <= '0;
								end else begin
									if (fail_q != 4'd15) fail_q <= fail_q + 1'b1;
									if (r_nd_q) begin
										if (nd_q[pend_idx_q] >= 2'd2) begin
											nd_q[pend_idx_q] <= 2'd3;
											sup_q[pend_idx_q] <= 1'b0;
											dis_q <= 1'b1;
										end else begin
											nd_q[pend_idx_q] <= nd_q[pend_idx_q] + 1'b1;
										end
									end
								end
							end
						end
						default: ;
					endcase
				end
				// bring the successor of the scan index into range by repeated subtraction
				ST_WRAP: begin
					if (left_q >= count_q) begin
						left_q <= left_q - count_q;
					end else begin
						ptr_q <= left_q[IW-1:0];
						scan_q <= left_q[IW-1:0];
						left_q <= count_q;
						state_q <= ST_SCAN;
					end
				end
				// one table entry per cycle
				ST_MAP: begin
					if (left_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						if (known_q && id_q[ptr_q] >= 8'd1 && id_q[ptr_q] <= 8'd32) begin
							sup_q[ptr_q] <= bits_q[5'(8'd32 - id_q[ptr_q])];
						end else begin
							sup_q[ptr_q] <= 1'b1;
						end
						ptr_q <= ptr_q + 1'b1;
						left_q <= left_q - 1'b1;
					end
				end
				// shared multiplier: tier interval and elapsed time of the entry
				ST_SCAN: begin
					ivl_q <= {8'd0, 24'(base_q) * 24'(mult_sel)};
					elapsed_q <= now_q - last_poll_q[ptr_q];
					state_q <= ST_MUL;
				end
				// compare and advance
				ST_MUL: begin
					if (sup_q[ptr_q] && elapsed_q >= ivl_q) begin
						last_att_q <= now_q;
						pend_idx_q <= ptr_q;
						pend_time_q <= now_q;
						pend_valid_q <= 1'b1;
						act_q <= ACT_REQUEST;
						req_q <= id_q[ptr_q];
						state_q <= ST_DONE;
					end else if (left_q == CW'(1)) begin
						state_q <= ST_DONE;
					end else begin
						left_q <= left_q - 1'b1;
						ptr_q <= next_idx;
						scan_q <= next_idx;
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (out_acc) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	`ASSERT_IMPL(a_req_pending, clk, arst_n, out_valid && action == ACT_REQUEST,
		pend_valid_q, "request issued without pending entry")
	`ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(MAX_ENTRIES),
		"entry count above table size")
	`ASSERT_NEXT(a_done_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(action),
		"result changed while stalled")
endmodule
`default_nettype wire
